// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    // Default geometry
    localparam int LEVELS_DEFAULT = 4;
    localparam int DEPTH_DEFAULT  = 16;

    // Field widths fixed by the interface
    localparam int HANDLE_W = 16;
    localparam int PRIO_W   = 2;
    localparam int STATUS_W = 2;

    // Action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Controller states
    typedef enum logic
    {
        ST_IDLE,
        ST_RESP
    } state_t;

    // Controller to datapath commands
    typedef struct packed
    {
        logic load;
    } ctrl_cmd_t;

endpackage

// ===== rtl/strict_priority_multi_fifo_unit.sv =====
// Result: an accepted request has its result valid in the cycle after it is accepted.
// Throughput: one request per cycle while out_stall is low; the next request enters as the
// result is taken. The entry store has a single registered read port.
// Reset: asynchronous active-low rst_n empties every level (head pointers and fill
// counts to zero); entry store contents are not cleared and need no clearing pass.
module strict_priority_multi_fifo_unit #(
    parameter int LEVELS = spq_pkg::LEVELS_DEFAULT,
    parameter int DEPTH  = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [spq_pkg::PRIO_W-1:0]      priority_req,
    input  logic [spq_pkg::HANDLE_W-1:0]    payload,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [spq_pkg::STATUS_W-1:0]    status,
    output logic [spq_pkg::HANDLE_W-1:0]    out_payload,
    output logic [spq_pkg::PRIO_W-1:0]      out_priority
);

    spq_pkg::ctrl_cmd_t cmd;

    // Handshake controller
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Queue state and entry store
    spq_datapath #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .priority_req (priority_req),
        .payload      (payload),
        .status       (status),
        .out_payload  (out_payload),
        .out_priority (out_priority)
    );

endmodule

// ===== rtl/spq_ram.sv =====
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output spq_pkg::ctrl_cmd_t  cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs; a new request enters as the result leaves
    always_comb
    begin
        out_valid  = 1'b0;
        in_stall   = 1'b0;
        cmd.load   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = spq_pkg::ST_RESP;
                end
            end
            spq_pkg::ST_RESP:
            begin
                out_valid = 1'b1;
                in_stall  = out_stall;
                cmd.load  = in_valid && !out_stall;
                if (!out_stall && !in_valid)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/spq_datapath.sv =====
module spq_datapath #(
    parameter int LEVELS = spq_pkg::LEVELS_DEFAULT,
    parameter int DEPTH  = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_pkg::ctrl_cmd_t              cmd,
    input  logic                            action,
    input  logic [spq_pkg::PRIO_W-1:0]      priority_req,
    input  logic [spq_pkg::HANDLE_W-1:0]    payload,
    output logic [spq_pkg::STATUS_W-1:0]    status,
    output logic [spq_pkg::HANDLE_W-1:0]    out_payload,
    output logic [spq_pkg::PRIO_W-1:0]      out_priority
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOTS  = LEVELS * DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];

    logic [spq_pkg::STATUS_W-1:0] status_reg;
    logic [spq_pkg::PRIO_W-1:0]   level_reg;
    logic                         deq_ok_reg;

    logic [LVL_W+1:0]  prio_wide;
    logic [LVL_W-1:0]  enq_lvl;
    logic              enq_ok;
    logic [PTR_W:0]    tail_sum;
    logic [PTR_W-1:0]  tail_slot;
    logic              deq_found;
    logic [LVL_W-1:0]  deq_lvl;
    logic [LVL_W+1:0]  deq_lvl_wide;
    logic              deq_ok;
    logic [PTR_W-1:0]  head_inc;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              ram_we;
    logic              ram_re;
    logic [spq_pkg::HANDLE_W-1:0] ram_rdata;

    // Enqueue side: level check and tail slot of the ring
    assign prio_wide = (LVL_W + 2)'(priority_req);
    assign enq_lvl   = prio_wide[LVL_W-1:0];
    assign enq_ok    = (action == spq_pkg::ACT_ENQ)
                     && (int'(priority_req) < LEVELS)
                     && (count_reg[enq_lvl] != CNT_W'(DEPTH));

    always_comb
    begin
        tail_sum = (PTR_W + 1)'(head_reg[enq_lvl]) + (PTR_W + 1)'(count_reg[enq_lvl]);
        if (tail_sum >= (PTR_W + 1)'(DEPTH))
        begin
            tail_sum = tail_sum - (PTR_W + 1)'(DEPTH);
        end
        tail_slot = tail_sum[PTR_W-1:0];
    end

    // Dequeue side: lowest-numbered non-empty level
    always_comb
    begin
        deq_found = 1'b0;
        deq_lvl   = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (!deq_found && (count_reg[i] != '0))
            begin
                deq_found = 1'b1;
                deq_lvl   = LVL_W'(i);
            end
        end
    end

    assign deq_ok       = (action == spq_pkg::ACT_DEQ) && deq_found;
    assign deq_lvl_wide = (LVL_W + 2)'(deq_lvl);

    always_comb
    begin
        if (head_reg[deq_lvl] == PTR_W'(DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg[deq_lvl] + PTR_W'(1);
        end
    end

    // Entry store addressing
    assign waddr  = ADDR_W'(enq_lvl) * ADDR_W'(DEPTH) + ADDR_W'(tail_slot);
    assign raddr  = ADDR_W'(deq_lvl) * ADDR_W'(DEPTH) + ADDR_W'(head_reg[deq_lvl]);
    assign ram_we = cmd.load && enq_ok;
    assign ram_re = cmd.load && deq_ok;

    spq_ram #(
        .WIDTH (spq_pkg::HANDLE_W),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (payload),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Per-level head pointers and fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (ram_we)
        begin
            count_reg[enq_lvl] <= count_reg[enq_lvl] + CNT_W'(1);
        end
        else if (ram_re)
        begin
            head_reg[deq_lvl]  <= head_inc;
            count_reg[deq_lvl] <= count_reg[deq_lvl] - CNT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= spq_pkg::STATUS_OK;
            level_reg  <= '0;
            deq_ok_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            deq_ok_reg <= deq_ok;
            level_reg  <= deq_ok ? deq_lvl_wide[spq_pkg::PRIO_W-1:0] : '0;
            if (action == spq_pkg::ACT_ENQ)
            begin
                status_reg <= enq_ok ? spq_pkg::STATUS_OK : spq_pkg::STATUS_FULL;
            end
            else
            begin
                status_reg <= deq_ok ? spq_pkg::STATUS_OK : spq_pkg::STATUS_EMPTY;
            end
        end
    end

    assign status       = status_reg;
    assign out_priority = level_reg;
    assign out_payload  = deq_ok_reg ? ram_rdata : '0;

endmodule
